// File: hdl/baac_pkg.sv
// shared types and constants for the box average luma ascii cell block
package baac_pkg;

	localparam int DEF_MAX_SRC_WIDTH    = 2048;
	localparam int DEF_MAX_SRC_HEIGHT   = 2048;
	localparam int DEF_MAX_CELLS_ACROSS = 512;
	localparam int DEF_MAX_RAMP_LENGTH  = 16;

	localparam int DIV_W  = 32;
	localparam int DEN_W  = 25;
	localparam int SUM_W  = 30;
	localparam int LUMA_W = 24;

	localparam logic [LUMA_W-1:0] LUMA_DEN     = 24'd16711680;
	localparam logic [LUMA_W-1:0] LUMA_HALF    = 24'd8355840;
	localparam logic [15:0]       WEIGHT_RED   = 16'd13933;
	localparam logic [15:0]       WEIGHT_GREEN = 16'd46871;
	localparam logic [15:0]       WEIGHT_BLUE  = 16'd4732;

	localparam logic [7:0] CHAR_SPACE   = 8'd32;
	localparam logic [7:0] CHAR_NEWLINE = 8'd10;

	localparam logic [11:0] RST_SRC_WIDTH   = 12'd640;
	localparam logic [11:0] RST_SRC_HEIGHT  = 12'd480;
	localparam logic [9:0]  RST_CELLS_ACR   = 10'd120;
	localparam logic [11:0] RST_CELLS_DOWN  = 12'd45;
	localparam logic [63:0] RST_RAMP_LOW    = 64'd2533885282101112352;
	localparam logic [63:0] RST_RAMP_HIGH   = 64'd16421;
	localparam logic [4:0]  RST_RAMP_LENGTH = 5'd10;

	typedef enum logic [2:0] {
		REG_SRC_WIDTH   = 3'd0,
		REG_SRC_HEIGHT  = 3'd1,
		REG_CELLS_ACR   = 3'd2,
		REG_CELLS_DOWN  = 3'd3,
		REG_RAMP_LOW    = 3'd4,
		REG_RAMP_HIGH   = 3'd5,
		REG_RAMP_LENGTH = 3'd6,
		REG_INVERT      = 3'd7
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV_X0,
		ST_DIV_X1,
		ST_DIV_Y0,
		ST_DIV_Y1,
		ST_UPD,
		ST_CELLN,
		ST_DIV_R,
		ST_DIV_G,
		ST_DIV_B,
		ST_LUMA,
		ST_INDEX,
		ST_DIV_IDX,
		ST_EMIT_CHAR,
		ST_EMIT_NL
	} state_t;

endpackage

// File: hdl/box_average_luma_ascii_cells.sv
// top level of the box average luma ascii cell block
//
// pixels come in raster order on the input channel (in_valid / in_stall), one
// word per source pixel with frame_start, red, green, blue. each cell-closing
// pixel in a band's last row gives one character word on the output channel
// (out_valid / out_stall); if such a pixel ends a source row it also gives a
// newline word, with frame_done set on the frame's final newline.
// per-column-cell channel sums live in one synchronous memory (read, add,
// write back); one pixel is worked at a time, so there is no access overlap.
// a shared restoring divider, one quotient bit a cycle, sets the pace:
// a pixel that closes no cell takes four split point divisions, a
// cell-closing pixel also three averages, luma and a threshold compare for
// the ramp index, plus any time a word waits on out_stall.
// the result sits in an output register; after the last word of a pixel is
// loaded the block takes the next pixel even while that word is stalled.
// reset clears position and out_valid and loads the default registers; the sum
// memory is not cleared, as the first pixel of every cell overwrites it.
// configuration is an apb-style port, 64-bit data, register i at byte 8*i.
module box_average_luma_ascii_cells #(
	parameter int MAX_SRC_WIDTH    = baac_pkg::DEF_MAX_SRC_WIDTH,
	parameter int MAX_SRC_HEIGHT   = baac_pkg::DEF_MAX_SRC_HEIGHT,
	parameter int MAX_CELLS_ACROSS = baac_pkg::DEF_MAX_CELLS_ACROSS,
	parameter int MAX_RAMP_LENGTH  = baac_pkg::DEF_MAX_RAMP_LENGTH
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	// pixel words
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        frame_start,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	// character words
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  character,
	output logic        last,
	output logic        frame_done
);

	localparam int XW  = $clog2(MAX_SRC_WIDTH) + 1;
	localparam int YW  = $clog2(MAX_SRC_HEIGHT) + 1;
	localparam int CW  = $clog2(MAX_CELLS_ACROSS);
	localparam int OW  = CW + 1;
	localparam int CNW = $clog2(baac_pkg::DIV_W + 1);
	localparam int SW  = baac_pkg::SUM_W;
	localparam int NW  = XW + YW;
	localparam logic [13:0] MAXW14 = 14'(MAX_SRC_WIDTH);
	localparam logic [13:0] MAXH14 = 14'(MAX_SRC_HEIGHT);
	localparam logic [13:0] MAXC14 = 14'(MAX_CELLS_ACROSS);
	localparam logic [4:0]  MAXR5  = 5'(MAX_RAMP_LENGTH);

	// configuration registers
	logic [11:0] src_w_q, src_h_q, cells_down_q;
	logic [9:0]  cells_acr_q;
	logic [63:0] ramp_low_q, ramp_high_q;
	logic [4:0]  ramp_len_q;
	logic        invert_q;

	baac_pkg::reg_idx_t wr_idx, rd_idx;
	assign wr_idx = baac_pkg::reg_idx_t'(paddr[5:3]);
	assign rd_idx = baac_pkg::reg_idx_t'(paddr[5:3]);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q      <= baac_pkg::RST_SRC_WIDTH;
			src_h_q      <= baac_pkg::RST_SRC_HEIGHT;
			cells_acr_q  <= baac_pkg::RST_CELLS_ACR;
			cells_down_q <= baac_pkg::RST_CELLS_DOWN;
			ramp_low_q   <= baac_pkg::RST_RAMP_LOW;
			ramp_high_q  <= baac_pkg::RST_RAMP_HIGH;
			ramp_len_q   <= baac_pkg::RST_RAMP_LENGTH;
			invert_q     <= 1'b0;
		end else if (psel && penable && pwrite && pready) begin
			case (wr_idx)
				baac_pkg::REG_SRC_WIDTH:   src_w_q      <= pwdata[11:0];
				baac_pkg::REG_SRC_HEIGHT:  src_h_q      <= pwdata[11:0];
				baac_pkg::REG_CELLS_ACR:   cells_acr_q  <= pwdata[9:0];
				baac_pkg::REG_CELLS_DOWN:  cells_down_q <= pwdata[11:0];
				baac_pkg::REG_RAMP_LOW:    ramp_low_q   <= pwdata;
				baac_pkg::REG_RAMP_HIGH:   ramp_high_q  <= pwdata;
				baac_pkg::REG_RAMP_LENGTH: ramp_len_q   <= pwdata[4:0];
				baac_pkg::REG_INVERT:      invert_q     <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (rd_idx)
			baac_pkg::REG_SRC_WIDTH:   prdata = {52'd0, src_w_q};
			baac_pkg::REG_SRC_HEIGHT:  prdata = {52'd0, src_h_q};
			baac_pkg::REG_CELLS_ACR:   prdata = {54'd0, cells_acr_q};
			baac_pkg::REG_CELLS_DOWN:  prdata = {52'd0, cells_down_q};
			baac_pkg::REG_RAMP_LOW:    prdata = ramp_low_q;
			baac_pkg::REG_RAMP_HIGH:   prdata = ramp_high_q;
			baac_pkg::REG_RAMP_LENGTH: prdata = {59'd0, ramp_len_q};
			baac_pkg::REG_INVERT:      prdata = {63'd0, invert_q};
			default:                   prdata = '0;
		endcase
	end

	// effective sizes: clamp to 1..max, cells never exceed source pixels
	logic [13:0] w14, h14, lim14, ow14, oh14;
	logic [XW-1:0] w_eff;
	logic [YW-1:0] h_eff, oh_eff;
	logic [OW-1:0] ow_eff;
	logic [4:0]    nramp;

	always_comb begin
		w14 = (src_w_q == 12'd0) ? 14'd1 : ((14'(src_w_q) > MAXW14) ? MAXW14 : 14'(src_w_q));
		h14 = (src_h_q == 12'd0) ? 14'd1 : ((14'(src_h_q) > MAXH14) ? MAXH14 : 14'(src_h_q));
		lim14 = (w14 < MAXC14) ? w14 : MAXC14;
		ow14 = (cells_acr_q == 10'd0) ? 14'd1 :
			((14'(cells_acr_q) > lim14) ? lim14 : 14'(cells_acr_q));
		oh14 = (cells_down_q == 12'd0) ? 14'd1 :
			((14'(cells_down_q) > h14) ? h14 : 14'(cells_down_q));
		w_eff  = XW'(w14);
		h_eff  = YW'(h14);
		ow_eff = OW'(ow14);
		oh_eff = YW'(oh14);
		nramp  = (ramp_len_q > MAXR5) ? MAXR5 : ramp_len_q;
	end

	// position state
	logic [XW-1:0] col_q;
	logic [YW-1:0] row_q, band_q, bfirst_q;
	logic [CW-1:0] cell_q;
	logic [XW-1:0] x0_q, x1_q;
	logic [YW-1:0] y0_q, y1_q;
	logic [7:0]    pix_r_q, pix_g_q, pix_b_q;
	logic          fs_q;
	logic          row_end_q, row_last_q;

	// shared divider
	logic [baac_pkg::DIV_W-1:0] div_q_q;
	logic [baac_pkg::DEN_W-1:0] div_r_q, div_den_q;
	logic [CNW-1:0]             div_cnt_q;
	logic                       div_busy_q;
	logic                       div_load;
	logic [baac_pkg::DIV_W-1:0] div_num_d;
	logic [baac_pkg::DEN_W-1:0] div_den_d;
	logic [baac_pkg::DEN_W:0]   div_rs;
	logic                       div_ge;

	assign div_rs = {div_r_q, div_q_q[baac_pkg::DIV_W-1]};
	assign div_ge = div_rs >= {1'b0, div_den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_cnt_q  <= '0;
		end else if (div_load) begin
			div_busy_q <= 1'b1;
			div_cnt_q  <= CNW'(baac_pkg::DIV_W);
		end else if (div_busy_q) begin
			div_cnt_q <= div_cnt_q - 1'b1;
			if (div_cnt_q == CNW'(1))
				div_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (div_load) begin
			div_q_q   <= div_num_d;
			div_r_q   <= '0;
			div_den_q <= div_den_d;
		end else if (div_busy_q) begin
			div_q_q <= {div_q_q[baac_pkg::DIV_W-2:0], div_ge};
			div_r_q <= div_ge ? baac_pkg::DEN_W'(div_rs - {1'b0, div_den_q})
				: baac_pkg::DEN_W'(div_rs);
		end
	end

	// sum memory: red, green, blue sums of one column cell per entry
	logic [3*SW-1:0] sum_mem [MAX_CELLS_ACROSS];
	logic [3*SW-1:0] sum_rd_q;
	logic [3*SW-1:0] sum_wr;
	logic            mem_rd, mem_wr;

	always_ff @(posedge clk) begin
		if (mem_wr)
			sum_mem[cell_q] <= sum_wr;
		if (mem_rd)
			sum_rd_q <= sum_mem[cell_q];
	end

	// read-modify of the sums
	logic          first_px;
	logic [SW-1:0] old_r, old_g, old_b;
	always_comb begin
		first_px = (row_q == bfirst_q) && (col_q == x0_q);
		old_r = sum_rd_q[3*SW-1:2*SW];
		old_g = sum_rd_q[2*SW-1:SW];
		old_b = sum_rd_q[SW-1:0];
		if (first_px)
			sum_wr = {SW'(pix_r_q), SW'(pix_g_q), SW'(pix_b_q)};
		else
			sum_wr = {old_r + SW'(pix_r_q), old_g + SW'(pix_g_q), old_b + SW'(pix_b_q)};
	end

	// cell close conditions
	logic [XW:0] col_p1;
	logic [YW:0] row_p1;
	logic        row_end, cell_end, row_last, band_last;
	always_comb begin
		col_p1    = {1'b0, col_q} + 1'b1;
		row_p1    = {1'b0, row_q} + 1'b1;
		row_end   = col_p1 >= {1'b0, w_eff};
		cell_end  = row_end || (col_p1 >= {1'b0, x1_q});
		row_last  = row_p1 >= {1'b0, h_eff};
		band_last = row_last || (row_p1 >= {1'b0, y1_q});
	end

	// restart when asked or when the position falls outside the sizes
	logic restart;
	assign restart = fs_q || (col_q >= w_eff) || (row_q >= h_eff) ||
		({1'b0, cell_q} >= ow_eff) || (band_q >= oh_eff);

	// cell result pipeline registers
	localparam int LUMA_WD = baac_pkg::LUMA_W;
	localparam int PW      = LUMA_WD + 4;
	logic [SW-1:0]     sum_r_q, sum_g_q, sum_b_q;
	logic [NW-1:0]     ncell_q;
	logic [7:0]        avg_r_q, avg_g_q, avg_b_q;
	logic [LUMA_WD-1:0] lum_q;
	logic [PW-1:0]     prod_q;
	logic [7:0]        glyph_q;
	logic [7:0]        quot_sat;
	logic [LUMA_WD+1:0] lum_raw;
	logic [LUMA_WD-1:0] lum_clip;
	logic [3:0]        ridx;
	logic [127:0]      ramp_all;

	assign quot_sat = (div_q_q > baac_pkg::DIV_W'(255)) ? 8'd255 : div_q_q[7:0];
	assign ramp_all = {ramp_high_q, ramp_low_q};

	always_comb begin
		lum_raw = (LUMA_WD+2)'(baac_pkg::WEIGHT_RED * avg_r_q)
			+ (LUMA_WD+2)'(baac_pkg::WEIGHT_GREEN * avg_g_q)
			+ (LUMA_WD+2)'(baac_pkg::WEIGHT_BLUE * avg_b_q);
		lum_clip = (lum_raw > (LUMA_WD+2)'(baac_pkg::LUMA_DEN)) ? baac_pkg::LUMA_DEN
			: LUMA_WD'(lum_raw);
		if (invert_q)
			lum_clip = baac_pkg::LUMA_DEN - lum_clip;
	end

	// ramp index: round half up of l*(n-1)/d, that is the count of the
	// thresholds (2k-1)*d/2 that l*(n-1) reaches; never above n-1 as l <= d
	always_comb begin
		ridx = 4'd0;
		for (int k = 1; k < 16; k++) begin
			if (prod_q >= PW'((2 * k - 1) * baac_pkg::LUMA_HALF))
				ridx = 4'(k);
		end
	end

	// output register
	logic       out_valid_q, last_q, fdone_q;
	logic [7:0] char_q;
	logic       out_free, out_load;
	logic [7:0] out_char_d;
	logic       out_last_d, out_fdone_d;

	assign out_free   = !out_valid_q || !out_stall;
	assign out_valid  = out_valid_q;
	assign character  = char_q;
	assign last       = last_q;
	assign frame_done = fdone_q;

	// sequencer
	baac_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= baac_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d     = state_q;
		div_load    = 1'b0;
		div_num_d   = '0;
		div_den_d   = '0;
		mem_rd      = 1'b0;
		mem_wr      = 1'b0;
		out_load    = 1'b0;
		out_char_d  = glyph_q;
		out_last_d  = 1'b0;
		out_fdone_d = 1'b0;
		in_stall    = 1'b1;
		case (state_q)
			baac_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid)
					state_d = baac_pkg::ST_PREP;
			end
			baac_pkg::ST_PREP: begin
				// a restarting pixel sits in cell zero
				div_load  = 1'b1;
				div_num_d = restart ? '0 : baac_pkg::DIV_W'(OW'(cell_q) * w_eff);
				div_den_d = baac_pkg::DEN_W'(ow_eff);
				state_d   = baac_pkg::ST_DIV_X0;
			end
			baac_pkg::ST_DIV_X0: if (!div_busy_q) begin
				div_load  = 1'b1;
				div_num_d = baac_pkg::DIV_W'((OW'(cell_q) + 1'b1) * w_eff);
				div_den_d = baac_pkg::DEN_W'(ow_eff);
				state_d   = baac_pkg::ST_DIV_X1;
			end
			baac_pkg::ST_DIV_X1: if (!div_busy_q) begin
				div_load  = 1'b1;
				div_num_d = baac_pkg::DIV_W'(band_q * h_eff);
				div_den_d = baac_pkg::DEN_W'(oh_eff);
				state_d   = baac_pkg::ST_DIV_Y0;
			end
			baac_pkg::ST_DIV_Y0: if (!div_busy_q) begin
				div_load  = 1'b1;
				div_num_d = baac_pkg::DIV_W'((band_q + 1'b1) * h_eff);
				div_den_d = baac_pkg::DEN_W'(oh_eff);
				state_d   = baac_pkg::ST_DIV_Y1;
			end
			baac_pkg::ST_DIV_Y1: if (!div_busy_q) begin
				mem_rd  = 1'b1;
				state_d = baac_pkg::ST_UPD;
			end
			baac_pkg::ST_UPD: begin
				mem_wr  = 1'b1;
				state_d = (cell_end && band_last) ? baac_pkg::ST_CELLN : baac_pkg::ST_IDLE;
			end
			baac_pkg::ST_CELLN: begin
				div_load  = 1'b1;
				div_num_d = baac_pkg::DIV_W'(sum_r_q);
				div_den_d = baac_pkg::DEN_W'(ncell_q);
				state_d   = baac_pkg::ST_DIV_R;
			end
			baac_pkg::ST_DIV_R: if (!div_busy_q) begin
				div_load  = 1'b1;
				div_num_d = baac_pkg::DIV_W'(sum_g_q);
				div_den_d = baac_pkg::DEN_W'(ncell_q);
				state_d   = baac_pkg::ST_DIV_G;
			end
			baac_pkg::ST_DIV_G: if (!div_busy_q) begin
				div_load  = 1'b1;
				div_num_d = baac_pkg::DIV_W'(sum_b_q);
				div_den_d = baac_pkg::DEN_W'(ncell_q);
				state_d   = baac_pkg::ST_DIV_B;
			end
			baac_pkg::ST_DIV_B: if (!div_busy_q) begin
				state_d = baac_pkg::ST_LUMA;
			end
			baac_pkg::ST_LUMA: begin
				state_d = baac_pkg::ST_INDEX;
			end
			baac_pkg::ST_INDEX: begin
				// empty ramp goes straight out as a space
				if (nramp == 5'd0)
					state_d = baac_pkg::ST_EMIT_CHAR;
				else
					state_d = baac_pkg::ST_DIV_IDX;
			end
			baac_pkg::ST_DIV_IDX: begin
				state_d = baac_pkg::ST_EMIT_CHAR;
			end
			baac_pkg::ST_EMIT_CHAR: if (out_free) begin
				out_load    = 1'b1;
				out_char_d  = glyph_q;
				out_last_d  = !row_end_q;
				state_d     = row_end_q ? baac_pkg::ST_EMIT_NL : baac_pkg::ST_IDLE;
			end
			baac_pkg::ST_EMIT_NL: if (out_free) begin
				out_load    = 1'b1;
				out_char_d  = baac_pkg::CHAR_NEWLINE;
				out_last_d  = 1'b1;
				out_fdone_d = row_last_q;
				state_d     = baac_pkg::ST_IDLE;
			end
			default: state_d = baac_pkg::ST_IDLE;
		endcase
	end

	// position registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			band_q   <= '0;
			bfirst_q <= '0;
			cell_q   <= '0;
		end else if (state_q == baac_pkg::ST_PREP && restart) begin
			col_q    <= '0;
			row_q    <= '0;
			band_q   <= '0;
			bfirst_q <= '0;
			cell_q   <= '0;
		end else if (state_q == baac_pkg::ST_UPD) begin
			if (row_end) begin
				col_q  <= '0;
				cell_q <= '0;
				if (band_last && row_last) begin
					row_q    <= '0;
					band_q   <= '0;
					bfirst_q <= '0;
				end else if (band_last) begin
					band_q   <= band_q + 1'b1;
					row_q    <= YW'(row_p1);
					bfirst_q <= YW'(row_p1);
				end else begin
					row_q <= YW'(row_p1);
				end
			end else begin
				col_q <= XW'(col_p1);
				if (cell_end)
					cell_q <= cell_q + 1'b1;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == baac_pkg::ST_IDLE && in_valid) begin
			fs_q    <= frame_start;
			pix_r_q <= red;
			pix_g_q <= green;
			pix_b_q <= blue;
		end
		if (state_q == baac_pkg::ST_DIV_X0 && !div_busy_q)
			x0_q <= XW'(div_q_q);
		if (state_q == baac_pkg::ST_DIV_X1 && !div_busy_q)
			x1_q <= XW'(div_q_q);
		if (state_q == baac_pkg::ST_DIV_Y0 && !div_busy_q)
			y0_q <= YW'(div_q_q);
		if (state_q == baac_pkg::ST_DIV_Y1 && !div_busy_q)
			y1_q <= YW'(div_q_q);
		if (state_q == baac_pkg::ST_UPD) begin
			sum_r_q    <= sum_wr[3*SW-1:2*SW];
			sum_g_q    <= sum_wr[2*SW-1:SW];
			sum_b_q    <= sum_wr[SW-1:0];
			ncell_q    <= NW'((x1_q - x0_q) * (y1_q - y0_q));
			row_end_q  <= row_end;
			row_last_q <= row_last;
		end
		if (state_q == baac_pkg::ST_DIV_R && !div_busy_q)
			avg_r_q <= quot_sat;
		if (state_q == baac_pkg::ST_DIV_G && !div_busy_q)
			avg_g_q <= quot_sat;
		if (state_q == baac_pkg::ST_DIV_B && !div_busy_q)
			avg_b_q <= quot_sat;
		if (state_q == baac_pkg::ST_LUMA)
			lum_q <= lum_clip;
		if (state_q == baac_pkg::ST_INDEX)
			prod_q <= PW'(lum_q * 4'(nramp - 5'd1));
		if (state_q == baac_pkg::ST_INDEX && nramp == 5'd0)
			glyph_q <= baac_pkg::CHAR_SPACE;
		if (state_q == baac_pkg::ST_DIV_IDX)
			glyph_q <= ramp_all[{ridx, 3'b000} +: 8];
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			char_q  <= out_char_d;
			last_q  <= out_last_d;
			fdone_q <= out_fdone_d;
		end
	end

endmodule

// File: hdl/baac_checker.sv
// port-level checks for the box average luma ascii cell block
module baac_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] character,
	input logic       last,
	input logic       frame_done,
	input logic       psel,
	input logic       penable,
	input logic       pready
);

	// a stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(character) && $stable(last)
			&& $stable(frame_done))
		else $error("stalled output word changed");

	// the frame end mark only rides on a closing newline
	a_frame_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_done |-> last && character == baac_pkg::CHAR_NEWLINE)
		else $error("frame_done on a word that is not the last newline");

	// one pixel at a time: an accepted pixel blocks the next cycle
	a_one_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("pixel accepted back to back");

	// config access never waits
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable |-> pready)
		else $error("config access stalled");

endmodule

bind box_average_luma_ascii_cells baac_checker u_baac_checker (.*);
